FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the component labeling block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition implies a consequence in the same cycle.
`define CCA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition implies a consequence in the next cycle.
`define CCA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/cca8_pkg.sv
// Package of the 8-way component labeling block: sequencer states, codes, defaults.
// No dependencies.
`default_nettype none

package cca8_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int CSR_DATA_W = 9;
   localparam int RESULT_W   = 15;
   localparam int ADDR_IN_W  = 16;

   localparam logic [CSR_DATA_W-1:0] DIM_RESET = 9'd256;

   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic KIND_COUNT = 1'b0;
   localparam logic KIND_LABEL = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SETUP,
      ST_EXEC,
      ST_READ_OUT,
      ST_L_ROW,
      ST_L_PIX,
      ST_L_UR,
      ST_L_NB,
      ST_L_MERGE,
      ST_UA_RD,
      ST_UA_CHK,
      ST_UB_RD,
      ST_UB_CHK,
      ST_L_FINISH,
      ST_R_RD,
      ST_R_CHK,
      ST_R_CP,
      ST_V_RD,
      ST_V_CHK,
      ST_V_WR
   } cca8_state_type;

endpackage

`default_nettype wire

FILE: src/connected_component_labeling_8way_core.sv
// Top level of the 8-way connected component labeling block.
// Depends on cca8_pkg, cca8_ram and assert_macros.svh.
//
//   Channel   Ports                                  Direction  Transfer when
//   request   start, busy, req_*                     in         start high, busy low
//   response  rsp_valid, rsp_result_kind/value       out        rsp_valid high (one cycle)
//   config    csr_write_enable, csr_index, csr_*     in         csr_write_enable high
//
// A plain load passes through the setup and execute states, then busy falls.
// A read adds a read-out state unless the address lies outside the frame;
// its response shows in the cycle busy falls.
// The last pixel starts labeling: a row step per row, then pixel, upper-right
// and neighbor steps per pixel, one merge step for each of the four scanned
// neighbors of a foreground pixel and union-find steps of one equivalence
// table read each; then a resolution pass over the provisional labels and a
// final relabel of every pixel, each memory having a single read port.
// Reset is synchronous; it clears the sequencer, the size registers, counters
// and the response flag; the memories need no clearing pass. The receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module connected_component_labeling_8way_core
#(
   parameter int MAX_WIDTH  = cca8_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = cca8_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_opcode,
   input  wire logic                              req_pixel_on,
   input  wire logic                              req_last_pixel,
   input  wire logic [cca8_pkg::ADDR_IN_W-1:0]    req_read_address,
   output logic                                   rsp_valid,
   output logic                                   rsp_result_kind,
   output logic      [cca8_pkg::RESULT_W-1:0]     rsp_result_value,
   input  wire logic                              csr_write_enable,
   input  wire logic                              csr_index,
   input  wire logic [cca8_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   import cca8_pkg::*;

   // Sizes derived from the frame limits.
   localparam int PIXELS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW     = $clog2(PIXELS);
   localparam int FW     = AW + 1;
   localparam int DW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   // Pixels that open a new provisional label never touch each other,
   // so this bounds the provisional label count.
   localparam int LBL    = ((MAX_WIDTH + 1) / 2) * ((MAX_HEIGHT + 1) / 2);
   localparam int LW     = $clog2(LBL + 1);
   localparam int CW     = (FW > ADDR_IN_W) ? FW : ADDR_IN_W;

   cca8_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic                  op_ff, op_in, on_ff, on_in, last_ff, last_in;
   logic [ADDR_IN_W-1:0]  addr_ff, addr_in;
   logic [DW-1:0]         wc_ff, wc_in, wc_clamp;
   logic [HW-1:0]         hc_ff, hc_in, hc_clamp;
   logic [FW-1:0]         frame_ff, frame_in;
   logic [FW-1:0]         load_pos_ff, load_pos_in;
   logic [LW-1:0]         pc_ff, pc_in, pc_fin;
   logic [LW-1:0]         total_ff, total_in;
   logic [DW-1:0]         x_ff, x_in;
   logic [HW-1:0]         y_ff, y_in;
   logic [AW-1:0]         p_ff, p_in;
   logic [LW-1:0]         m_ff, m_in;
   logic [LW-1:0]         nb_ff [4];
   logic [LW-1:0]         nb_in [4];
   logic                  cur_on_ff, cur_on_in;
   logic [1:0]            k_ff, k_in;
   logic [LW-1:0]         fcur_ff, fcur_in, ra_ff, ra_in;
   logic [LW-1:0]         i_ff, i_in;
   logic [AW-1:0]         j_ff, j_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_kind_ff, rsp_kind_in;
   logic [RESULT_W-1:0]   rsp_value_ff, rsp_value_in;

   // Memory ports.
   logic          st_wr_en, st_rd_en, eq_wr_en, eq_rd_en;
   logic [AW-1:0] st_wr_addr, st_rd_addr;
   logic [LW-1:0] st_wr_data, st_rd;
   logic [LW-1:0] eq_wr_addr, eq_rd_addr, eq_wr_data, eq_rd;

   // Decision signals shared by the next-state and datapath logic.
   logic          accept, in_range, fits, row_end, last_px, ur_ok;
   logic          merge_trivial, eq_hit, is_root, last_i, last_j, new_lbl;
   logic [LW-1:0] n_cur, lbl_fin;
   logic [CW-1:0] addr_ext;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign addr_ext = CW'(addr_ff);
   assign in_range = addr_ext < CW'(frame_ff);
   assign fits     = load_pos_ff < frame_ff;
   assign row_end  = (x_ff + DW'(1)) == wc_ff;
   assign last_px  = row_end && ((y_ff + HW'(1)) == hc_ff);
   assign ur_ok    = (y_ff != '0) && !row_end;
   assign n_cur    = nb_ff[k_ff];
   assign merge_trivial = (n_cur == '0) || (m_ff == '0) || (n_cur == m_ff);
   assign eq_hit   = (eq_rd == fcur_ff);
   assign is_root  = (eq_rd == i_ff) || (eq_rd == '0) || (eq_rd > i_ff);
   assign last_i   = (i_ff == pc_ff);
   assign last_j   = (FW'(j_ff) + FW'(1)) == frame_ff;
   assign new_lbl  = cur_on_ff && (m_ff == '0) && (pc_ff < LW'(LBL));
   assign pc_fin   = new_lbl ? pc_ff + LW'(1) : pc_ff;
   assign lbl_fin  = !cur_on_ff ? '0 : ((m_ff == '0) ? pc_fin : m_ff);

   // Register values of 0 act as 1, values above the limit act as the limit.
   always_comb begin
      if (width_ff == '0) begin
         wc_clamp = DW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         wc_clamp = DW'(MAX_WIDTH);
      end else begin
         wc_clamp = DW'(width_ff);
      end
      if (height_ff == '0) begin
         hc_clamp = HW'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         hc_clamp = HW'(MAX_HEIGHT);
      end else begin
         hc_clamp = HW'(height_ff);
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (accept) state_in = ST_SETUP;
         ST_SETUP:    state_in = ST_EXEC;
         ST_EXEC: begin
            if (op_ff == OP_READ) begin
               state_in = in_range ? ST_READ_OUT : ST_IDLE;
            end else begin
               state_in = last_ff ? ST_L_ROW : ST_IDLE;
            end
         end
         ST_READ_OUT: state_in = ST_IDLE;
         ST_L_ROW:    state_in = ST_L_PIX;
         ST_L_PIX:    state_in = ST_L_UR;
         ST_L_UR:     state_in = ST_L_NB;
         ST_L_NB:     state_in = cur_on_ff ? ST_L_MERGE : ST_L_FINISH;
         ST_L_MERGE: begin
            if (merge_trivial) begin
               state_in = (k_ff == 2'd3) ? ST_L_FINISH : ST_L_MERGE;
            end else begin
               state_in = ST_UA_RD;
            end
         end
         ST_UA_RD:    state_in = ST_UA_CHK;
         ST_UA_CHK:   state_in = eq_hit ? ST_UB_RD : ST_UA_RD;
         ST_UB_RD:    state_in = ST_UB_CHK;
         ST_UB_CHK: begin
            if (eq_hit) begin
               state_in = (k_ff == 2'd3) ? ST_L_FINISH : ST_L_MERGE;
            end else begin
               state_in = ST_UB_RD;
            end
         end
         ST_L_FINISH: begin
            if (last_px) begin
               state_in = (pc_fin == '0) ? ST_V_RD : ST_R_RD;
            end else begin
               state_in = row_end ? ST_L_ROW : ST_L_PIX;
            end
         end
         ST_R_RD:     state_in = ST_R_CHK;
         ST_R_CHK: begin
            if (is_root) begin
               state_in = last_i ? ST_V_RD : ST_R_RD;
            end else begin
               state_in = ST_R_CP;
            end
         end
         ST_R_CP:     state_in = last_i ? ST_V_RD : ST_R_RD;
         ST_V_RD:     state_in = ST_V_CHK;
         ST_V_CHK: begin
            if (st_rd == '0) begin
               state_in = last_j ? ST_IDLE : ST_V_RD;
            end else begin
               state_in = ST_V_WR;
            end
         end
         ST_V_WR:     state_in = last_j ? ST_IDLE : ST_V_RD;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath, memory controls and response.
   always_comb begin
      op_in        = op_ff;
      on_in        = on_ff;
      last_in      = last_ff;
      addr_in      = addr_ff;
      wc_in        = wc_ff;
      hc_in        = hc_ff;
      frame_in     = frame_ff;
      load_pos_in  = load_pos_ff;
      pc_in        = pc_ff;
      total_in     = total_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      p_in         = p_ff;
      m_in         = m_ff;
      nb_in        = nb_ff;
      cur_on_in    = cur_on_ff;
      k_in         = k_ff;
      fcur_in      = fcur_ff;
      ra_in        = ra_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      st_wr_en     = 1'b0;
      st_wr_addr   = p_ff;
      st_wr_data   = lbl_fin;
      st_rd_en     = 1'b0;
      st_rd_addr   = p_ff;
      eq_wr_en     = 1'b0;
      eq_wr_addr   = pc_fin;
      eq_wr_data   = pc_fin;
      eq_rd_en     = 1'b0;
      eq_rd_addr   = fcur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in   = req_opcode;
               on_in   = req_pixel_on;
               last_in = req_last_pixel;
               addr_in = req_read_address;
            end
         end
         ST_SETUP: begin
            wc_in    = wc_clamp;
            hc_in    = hc_clamp;
            frame_in = FW'(wc_clamp) * FW'(hc_clamp);
         end
         ST_EXEC: begin
            if (op_ff == OP_READ) begin
               if (in_range) begin
                  st_rd_en   = 1'b1;
                  st_rd_addr = addr_ext[AW-1:0];
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_LABEL;
                  rsp_value_in = '0;
               end
            end else begin
               if (fits) begin
                  st_wr_en    = 1'b1;
                  st_wr_addr  = load_pos_ff[AW-1:0];
                  st_wr_data  = LW'(on_ff);
                  load_pos_in = load_pos_ff + FW'(1);
               end
               if (last_ff) begin
                  x_in  = '0;
                  y_in  = '0;
                  p_in  = '0;
                  pc_in = '0;
               end
            end
         end
         ST_READ_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_LABEL;
            rsp_value_in = RESULT_W'(st_rd);
         end
         ST_L_ROW: begin
            if (y_ff != '0) begin
               st_rd_en   = 1'b1;
               st_rd_addr = p_ff - AW'(wc_ff);
            end
         end
         ST_L_PIX: begin
            // Start of a row: the window is reloaded from the row above.
            if (x_ff == '0) begin
               nb_in[0] = '0;
               nb_in[1] = '0;
               nb_in[2] = (y_ff != '0) ? st_rd : '0;
            end
            st_rd_en   = 1'b1;
            st_rd_addr = p_ff;
         end
         ST_L_UR: begin
            // Pixels past the loaded part of the frame count as background.
            cur_on_in = (st_rd != '0) && (FW'(p_ff) < load_pos_ff);
            m_in      = '0;
            if (ur_ok) begin
               st_rd_en   = 1'b1;
               st_rd_addr = p_ff - AW'(wc_ff) + AW'(1);
            end
         end
         ST_L_NB: begin
            nb_in[3] = ur_ok ? st_rd : '0;
            k_in     = '0;
         end
         ST_L_MERGE: begin
            if (merge_trivial) begin
               if (m_ff == '0) begin
                  m_in = n_cur;
               end
               k_in = k_ff + 2'd1;
            end else begin
               fcur_in = m_ff;
            end
         end
         ST_UA_RD, ST_UB_RD: begin
            eq_rd_en   = 1'b1;
            eq_rd_addr = fcur_ff;
         end
         ST_UA_CHK: begin
            if (eq_hit) begin
               ra_in   = fcur_ff;
               fcur_in = n_cur;
            end else begin
               fcur_in = eq_rd;
            end
         end
         ST_UB_CHK: begin
            if (eq_hit) begin
               // Link the larger root under the smaller one.
               if (ra_ff != fcur_ff) begin
                  eq_wr_en   = 1'b1;
                  eq_wr_addr = (ra_ff < fcur_ff) ? fcur_ff : ra_ff;
                  eq_wr_data = (ra_ff < fcur_ff) ? ra_ff : fcur_ff;
               end
               k_in = k_ff + 2'd1;
            end else begin
               fcur_in = eq_rd;
            end
         end
         ST_L_FINISH: begin
            if (new_lbl) begin
               pc_in    = pc_fin;
               eq_wr_en = 1'b1;
            end
            st_wr_en = 1'b1;
            nb_in[0] = lbl_fin;
            nb_in[1] = nb_ff[2];
            nb_in[2] = nb_ff[3];
            p_in     = p_ff + AW'(1);
            if (row_end) begin
               x_in = '0;
               y_in = y_ff + HW'(1);
            end else begin
               x_in = x_ff + DW'(1);
            end
            if (last_px) begin
               total_in = '0;
               i_in     = LW'(1);
               j_in     = '0;
            end
         end
         ST_R_RD: begin
            eq_rd_en   = 1'b1;
            eq_rd_addr = i_ff;
         end
         ST_R_CHK: begin
            if (is_root) begin
               total_in   = total_ff + LW'(1);
               eq_wr_en   = 1'b1;
               eq_wr_addr = i_ff;
               eq_wr_data = total_ff + LW'(1);
               i_in       = i_ff + LW'(1);
            end else begin
               eq_rd_en   = 1'b1;
               eq_rd_addr = eq_rd;
            end
         end
         ST_R_CP: begin
            eq_wr_en   = 1'b1;
            eq_wr_addr = i_ff;
            eq_wr_data = eq_rd;
            i_in       = i_ff + LW'(1);
         end
         ST_V_RD: begin
            st_rd_en   = 1'b1;
            st_rd_addr = j_ff;
         end
         ST_V_CHK: begin
            if (st_rd == '0) begin
               st_wr_en   = 1'b1;
               st_wr_addr = j_ff;
               st_wr_data = '0;
               j_in       = j_ff + AW'(1);
            end else begin
               eq_rd_en   = 1'b1;
               eq_rd_addr = st_rd;
            end
         end
         ST_V_WR: begin
            st_wr_en   = 1'b1;
            st_wr_addr = j_ff;
            st_wr_data = eq_rd;
            j_in       = j_ff + AW'(1);
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase

      // Frame done: report the component count and rearm the loader.
      if (((state_ff == ST_V_CHK) && (st_rd == '0) && last_j) ||
          ((state_ff == ST_V_WR) && last_j)) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = KIND_COUNT;
         rsp_value_in = RESULT_W'(total_ff);
         load_pos_in  = '0;
         pc_in        = '0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= DIM_RESET;
         height_ff    <= DIM_RESET;
         load_pos_ff  <= '0;
         pc_ff        <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         pc_ff        <= pc_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_WIDTH) begin
               width_ff <= csr_write_data;
            end
            if (csr_index == CSR_HEIGHT) begin
               height_ff <= csr_write_data;
            end
         end
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      on_ff        <= on_in;
      last_ff      <= last_in;
      addr_ff      <= addr_in;
      wc_ff        <= wc_in;
      hc_ff        <= hc_in;
      frame_ff     <= frame_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      p_ff         <= p_in;
      m_ff         <= m_in;
      nb_ff        <= nb_in;
      cur_on_ff    <= cur_on_in;
      k_ff         <= k_in;
      fcur_ff      <= fcur_in;
      ra_ff        <= ra_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
   end

   // Pixel bits while loading, provisional then final labels after.
   cca8_ram #(
      .WIDTH (LW),
      .DEPTH (PIXELS)
   ) u_label_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd)
   );

   // Union-find parents, then dense labels after resolution.
   cca8_ram #(
      .WIDTH (LW),
      .DEPTH (LBL + 1)
   ) u_equiv_table (
      .clock   (clock),
      .wr_en   (eq_wr_en),
      .wr_addr (eq_wr_addr),
      .wr_data (eq_wr_data),
      .rd_en   (eq_rd_en),
      .rd_addr (eq_rd_addr),
      .rd_data (eq_rd)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;

   `CCA_ASSERT_IMP(a_rsp_when_idle, clock, reset, rsp_valid_ff, !busy, "response while busy")
   `CCA_ASSERT_NXT(a_accept_busy, clock, reset, accept, state_ff == ST_SETUP, "transfer lost")
   `CCA_ASSERT_IMP(a_pc_bound, clock, reset, 1'b1, pc_ff <= LW'(LBL), "label count overflow")
   `CCA_ASSERT_IMP(a_fg_labeled, clock, reset, (state_ff == ST_L_FINISH) && cur_on_ff,
                   lbl_fin != '0, "foreground pixel left unlabeled")

endmodule

`default_nettype wire

FILE: src/cca8_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module cca8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
